// ===== hw/rtl/pno_pkg.sv =====
// shared types, constants and table builders for the note oscillator
`timescale 1ns / 1ps

package pno_pkg;

  localparam int NUM_VOICES_DEF      = 128;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_RATE         = 48000;
  localparam logic [15:0] GAIN_RESET = 16'd7864;

  // pi/2 in q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned INC_DEN     = 64'(SAMPLE_RATE) * 64'd16;

  // floor(2^30 / 127), used for the note-on amplitude divide
  localparam logic [23:0] RECIP_127 = 24'd8454660;

  // 2^(k/12) in q1.30
  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589836, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  // taylor denominators (2k)(2k+1)
  localparam longint unsigned TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_TICK     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] amp;
    logic [31:0] phase;
  } voice_entry_t;

  // per-note phase increment, scaled to 2^32 per turn
  function automatic logic [31:0] note_inc(input int unsigned n);
    int unsigned     e;
    int unsigned     oct6;
    int unsigned     semi;
    longint unsigned num;
    e    = n + 3;
    oct6 = e / 12;
    semi = e % 12;
    num  = (64'd440 * 64'(SEMITONE_Q30[semi])) << oct6;
    return 32'((num + INC_DEN / 2) / INC_DEN);
  endfunction

  // sine of a quarter-wave position in q30
  function automatic longint unsigned quarter_sine(input int unsigned t, input int bits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = (64'(t) * HALF_PI_Q30) >> (bits - 2);
    term = x;
    sum  = longint'(x);
    for (int k = 0; k < 5; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[k];
      if (k % 2 == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return longint'(sum);
  endfunction

  // one q1.15 entry of the full sine table
  function automatic logic [15:0] sine_entry(input int unsigned i, input int bits);
    int unsigned     quarter;
    int unsigned     quad;
    int unsigned     r;
    int unsigned     t;
    longint unsigned s;
    longint unsigned v;
    quarter = 1 << (bits - 2);
    quad    = (i >> (bits - 2)) & 3;
    r       = i & (quarter - 1);
    t       = ((quad & 1) != 0) ? (quarter - r) : r;
    s       = quarter_sine(t, bits);
    v       = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    if ((quad & 2) != 0) begin
      return 16'(-32'(v));
    end
    return 16'(v);
  endfunction

endpackage

// ===== hw/rtl/pno_voice_mem.sv =====
// voice state memory: amplitude and phase per voice, one write and one read port
`timescale 1ns / 1ps

module pno_voice_mem #(
  parameter int DEPTH  = pno_pkg::NUM_VOICES_DEF,
  parameter int ADDR_W = 7
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  pno_pkg::voice_entry_t wr_data,
  input  logic [ADDR_W-1:0]     rd_addr,
  output pno_pkg::voice_entry_t rd_data
);

  pno_pkg::voice_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/pno_sine_rom.sv =====
// sine rom with registered read, contents built at elaboration
`timescale 1ns / 1ps

module pno_sine_rom #(
  parameter int TABLE_BITS = pno_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic [TABLE_BITS-1:0]  addr,
  output logic signed [15:0]     data
);

  localparam int TABLE_SIZE = 1 << TABLE_BITS;

  logic [15:0] rom [TABLE_SIZE];

  genvar g;
  generate
    for (g = 0; g < TABLE_SIZE; g++) begin : g_rom
      assign rom[g] = pno_pkg::sine_entry(g, TABLE_BITS);
    end
  endgenerate

  always_ff @(posedge clk) begin
    data <= $signed(rom[addr]);
  end

endmodule

// ===== hw/rtl/pno_amp_calc.sv =====
// note-on amplitude: round(velocity * gain / 127) in three pipeline steps
`timescale 1ns / 1ps

module pno_amp_calc (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [6:0]  velocity,
  input  logic [15:0] gain,
  output logic        done,
  output logic [15:0] amp
);

  logic        valid1;
  logic        valid2;
  logic [22:0] n1;
  logic [22:0] n2;
  logic [15:0] q2;
  logic [46:0] recip_prod;
  logic [22:0] rem;

  assign recip_prod = 47'(n1) * 47'(pno_pkg::RECIP_127);
  assign rem        = n2 - 23'(q2) * 23'd127;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= start;
      valid2 <= valid1;
      done   <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    // product plus half of the divisor
    n1 <= 23'(velocity) * 23'(gain) + 23'd63;
    // reciprocal estimate, at most one low
    n2 <= n1;
    q2 <= recip_prod[45:30];
    // one correction step
    if (rem >= 23'd127) begin
      amp <= q2 + 16'd1;
    end else begin
      amp <= q2;
    end
  end

endmodule

// ===== hw/rtl/polyphonic_note_oscillator_core.sv =====
// polyphonic sine oscillator core: one voice per note, memory-walked mixing
`timescale 1ns / 1ps

// tick: busy for the voice walk, which reads one memory entry per cycle, and for the
//   drain of the walk pipeline; the sample strobe comes once the pipeline is empty
// note on: busy while the amplitude divide pipeline runs; note off: the core does not go busy
// sample_valid is a one-cycle strobe, the receiver cannot stall it
// reset (synchronous): all voices off, master gain 7864; the voice memory is not
//   cleared, a voice's entry is only used after a note on has written it

module polyphonic_note_oscillator_core #(
  parameter int NUM_VOICES      = pno_pkg::NUM_VOICES_DEF,
  parameter int SINE_TABLE_BITS = pno_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [6:0]         note,
  input  logic [6:0]         velocity,
  input  logic signed [15:0] buffer_in,
  // result
  output logic               sample_valid,
  output logic signed [15:0] sample_out,
  // master gain write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  // buffer term plus one full-scale product per voice, with headroom
  localparam int ACC_W  = 34 + VIDX_W;
  localparam int RND_W  = ACC_W - 16;
  localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(32767);
  localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(32768);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_AMP   = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0]           master_gain;
  logic [NUM_VOICES-1:0] active;
  logic [31:0]           inc_rom [NUM_VOICES];

  logic              accept;
  logic              note_ok;
  logic [VIDX_W-1:0] note_idx;
  logic [VIDX_W-1:0] note_sel;
  logic [VIDX_W-1:0] cnt;
  logic              walk_last;

  // walk pipeline: 1 = memory data, 2 = rom data, 3 = product
  logic              valid1;
  logic              act1;
  logic [VIDX_W-1:0] idx1;
  logic              valid2;
  logic              act2;
  logic [15:0]       amp2;
  logic              valid3;
  logic              act3;
  logic signed [32:0] prod3;
  logic signed [15:0] sine2;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RND_W-1:0] acc_q15;
  logic signed [15:0]      sat_val;

  // memory ports
  logic                  wr_en;
  logic [VIDX_W-1:0]     wr_addr;
  pno_pkg::voice_entry_t wr_data;
  pno_pkg::voice_entry_t rd_data;

  logic        amp_done;
  logic [15:0] amp_val;
  logic        amp_start;
  logic        pipe_empty;

  // per-note phase increments, constant table
  genvar g;
  generate
    for (g = 0; g < NUM_VOICES; g++) begin : g_inc
      assign inc_rom[g] = pno_pkg::note_inc(g);
    end
  endgenerate

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign note_ok   = ({1'b0, note} < 8'(NUM_VOICES));
  assign note_idx  = note[VIDX_W-1:0];
  assign walk_last = (cnt == VIDX_W'(NUM_VOICES - 1));
  assign pipe_empty = !valid1 && !valid2 && !valid3;

  assign amp_start = accept && (kind == pno_pkg::KIND_NOTE_ON) && note_ok;

  pno_amp_calc u_amp (
    .clk      (clk),
    .rst      (rst),
    .start    (amp_start),
    .velocity (velocity),
    .gain     (master_gain),
    .done     (amp_done),
    .amp      (amp_val)
  );

  // write port: phase write-back during a tick, new voice on note on
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx1;
    wr_data = '{amp: rd_data.amp, phase: rd_data.phase + inc_rom[idx1]};
    if (valid1 && act1) begin
      wr_en = 1'b1;
    end else if ((state == ST_AMP) && amp_done) begin
      wr_en   = 1'b1;
      wr_addr = note_sel;
      wr_data = '{amp: amp_val, phase: 32'd0};
    end
  end

  pno_voice_mem #(
    .DEPTH  (NUM_VOICES),
    .ADDR_W (VIDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  // table index is the top bits of the phase just read
  pno_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rd_data.phase[31 -: SINE_TABLE_BITS]),
    .data (sine2)
  );

  // rounding to q1.15 by adding half and flooring, then saturation
  always_comb begin
    acc_rnd = acc + ACC_W'(32'sd32768);
    acc_q15 = acc_rnd[ACC_W-1:16];
    if (acc_q15 > SAT_MAX) begin
      sat_val = 16'sh7fff;
    end else if (acc_q15 < SAT_MIN) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = acc_q15[15:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == pno_pkg::KIND_TICK)) begin
          state_next = ST_WALK;
        end else if (amp_start) begin
          state_next = ST_AMP;
        end
      end
      ST_AMP: begin
        if (amp_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      master_gain  <= pno_pkg::GAIN_RESET;
      active       <= '0;
      cnt          <= '0;
      valid1       <= 1'b0;
      valid2       <= 1'b0;
      valid3       <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      state        <= state_next;
      if (cfg_valid && cfg_ready) begin
        master_gain <= cfg_data;
      end
      // note off takes effect at the request edge
      if (accept && (kind == pno_pkg::KIND_NOTE_OFF) && note_ok) begin
        active[note_idx] <= 1'b0;
      end
      if ((state == ST_AMP) && amp_done) begin
        active[note_sel] <= 1'b1;
      end
      if (state == ST_WALK) begin
        cnt <= walk_last ? '0 : cnt + VIDX_W'(1);
      end
      valid1 <= (state == ST_WALK);
      valid2 <= valid1;
      valid3 <= valid2;
      // strobe once the last product is in the sum
      sample_valid <= (state == ST_DRAIN) && pipe_empty;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (amp_start) begin
      note_sel <= note_idx;
    end
    act1 <= active[cnt];
    idx1 <= cnt;
    act2 <= act1;
    amp2 <= rd_data.amp;
    act3 <= act2;
    prod3 <= sine2 * $signed({1'b0, amp2});
    if (accept && (kind == pno_pkg::KIND_TICK)) begin
      acc <= {{(ACC_W - 32){buffer_in[15]}}, buffer_in, 16'd0};
    end else if (valid3 && act3) begin
      acc <= acc + ACC_W'(prod3);
    end
    if ((state == ST_DRAIN) && pipe_empty) begin
      sample_out <= sat_val;
    end
  end

endmodule

// ===== bench/polyphonic_note_oscillator_core_tb.sv =====
// self-checking testbench for the polyphonic note oscillator core
`timescale 1ns / 1ps

module polyphonic_note_oscillator_core_tb;

  localparam int VOICES        = 128;
  localparam int TABLE_BITS    = 10;
  // a tick walks every voice, so leave a full walk plus margin before quiet actions
  localparam int SETTLE_CYCLES = VOICES + 12;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int PHASES        = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // mirror of the voice bank: keeps voice state and the expected mixed samples
  class sample_scoreboard;
    localparam int TABLE_SIZE     = 1 << TABLE_BITS;
    localparam int QUARTER        = TABLE_SIZE >> 2;
    localparam int SAMPLE_RATE_HZ = 48000;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam logic [31:0] SEMI_Q30 [12] = '{
      32'd1073741824, 32'd1137589836, 32'd1205234447, 32'd1276901417,
      32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
      32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
    };

    logic [15:0]        gain;
    bit                 voice_on [VOICES];
    logic [15:0]        voice_amp [VOICES];
    logic [31:0]        voice_phase [VOICES];
    logic [31:0]        phase_step [VOICES];
    logic signed [15:0] sine_q15 [TABLE_SIZE];
    logic signed [15:0] expected_samples [$];
    int                 mismatches;

    function new();
      int unsigned     quad;
      int unsigned     r;
      int unsigned     t;
      int unsigned     e;
      longint unsigned s;
      longint unsigned v;
      longint unsigned num;
      longint unsigned den;
      gain       = pno_pkg::GAIN_RESET;
      mismatches = 0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        quad = (i / QUARTER) & 3;
        r    = i % QUARTER;
        t    = ((quad & 1) != 0) ? (QUARTER - r) : r;
        s    = quarter_turn_sine(t);
        v    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
          v = 64'd32767;
        end
        sine_q15[i] = ((quad & 2) != 0) ? -16'(v) : 16'(v);
      end
      // increment = 440 * 2^((n-69)/12) * 2^32 / rate, built from octave and semitone
      den = 64'(SAMPLE_RATE_HZ) * 64'd16;
      for (int n = 0; n < VOICES; n++) begin
        e             = n + 3;
        num           = (64'd440 * 64'(SEMI_Q30[e % 12])) << (e / 12);
        phase_step[n] = 32'((num + den / 2) / den);
        voice_on[n]    = 1'b0;
        voice_amp[n]   = '0;
        voice_phase[n] = '0;
      end
    endfunction

    // taylor series up to x^11 in q30, x = t/QUARTER * pi/2
    function longint unsigned quarter_turn_sine(int unsigned t);
      longint unsigned x;
      longint unsigned power;
      longint          series;
      x      = (64'(t) * HALF_PI) >> (TABLE_BITS - 2);
      power  = x;
      series = longint'(x);
      for (int k = 1; k <= 5; k++) begin
        power = (power * x) >> 30;
        power = (power * x) >> 30;
        power = power / longint'((2 * k) * (2 * k + 1));
        if ((k & 1) != 0) begin
          series = series - longint'(power);
        end else begin
          series = series + longint'(power);
        end
      end
      if (series < 0) begin
        series = 0;
      end
      return longint'(series);
    endfunction

    function void set_gain(logic [15:0] value);
      gain = value;
    endfunction

    // sum every active voice onto the buffer sample, then advance their phases
    function logic signed [15:0] mix_voices(logic signed [15:0] base);
      longint      acc;
      int unsigned idx;
      acc = longint'(base) * 64'sd65536;
      for (int n = 0; n < VOICES; n++) begin
        if (voice_on[n]) begin
          idx            = voice_phase[n] >> (32 - TABLE_BITS);
          acc            = acc + longint'(sine_q15[idx]) * longint'(voice_amp[n]);
          voice_phase[n] = voice_phase[n] + phase_step[n];
        end
      end
      acc = (acc + 64'sd32768) >>> 16;
      if (acc > 64'sd32767) begin
        acc = 64'sd32767;
      end
      if (acc < -64'sd32768) begin
        acc = -64'sd32768;
      end
      return 16'(acc);
    endfunction

    // called for each accepted request
    function void note_request(logic [1:0] k, logic [6:0] n, logic [6:0] vel,
                               logic signed [15:0] base);
      int unsigned prod;
      case (k)
        pno_pkg::KIND_NOTE_ON: begin
          prod           = int'(vel) * int'(gain);
          voice_on[n]    = 1'b1;
          voice_phase[n] = '0;
          voice_amp[n]   = 16'((prod + 63) / 127);
        end
        pno_pkg::KIND_NOTE_OFF: begin
          voice_on[n] = 1'b0;
        end
        pno_pkg::KIND_TICK: begin
          expected_samples.insert(expected_samples.size(), mix_voices(base));
        end
        default: begin
        end
      endcase
    endfunction

    function void check_sample(logic signed [15:0] actual);
      logic signed [15:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample_out: unexpected result, actual %0d", actual);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (actual !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, actual);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         kind;
  logic [6:0]         note;
  logic [6:0]         velocity;
  logic signed [15:0] buffer_in;
  logic               sample_valid;
  logic signed [15:0] sample_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  sample_scoreboard sb;
  bit               idle_on;
  int               quiet_cycles;

  polyphonic_note_oscillator_core #(
    .NUM_VOICES      (VOICES),
    .SINE_TABLE_BITS (TABLE_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .note         (note),
    .velocity     (velocity),
    .buffer_in    (buffer_in),
    .sample_valid (sample_valid),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // results cannot be held off, so every strobe is checked as it comes
  always @(posedge clk) begin
    if (!rst && sample_valid) begin
      sb.check_sample(sample_out);
    end
  end

  // watchdog: any request, result or register write counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || sample_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // idle length before the next request or write: mostly short, now and then long
  // enough to land anywhere inside a voice walk
  function automatic int idle_gap();
    if (!idle_on || $urandom_range(99) >= 15) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(150, 1);
    end
    return $urandom_range(4, 1);
  endfunction

  // drive one request, hold it until the core takes it
  task automatic send(logic [1:0] k, logic [6:0] n, logic [6:0] vel,
                      logic signed [15:0] base);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    kind      <= k;
    note      <= n;
    velocity  <= vel;
    buffer_in <= base;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(k, n, vel, base);
  endtask

  // drop start and wait until every sample is back and the core has gone quiet
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [15:0] value);
    int gap;
    gap = idle_gap();
    repeat (gap) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_gain(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 16'sh7fff;
    end else if (r == 1) begin
      return -16'sh8000;
    end else if (r < 5) begin
      return 16'($urandom_range(511) - 256);
    end
    return 16'($urandom);
  endfunction

  function automatic logic [6:0] pick_velocity();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 7'd127;
    end else if (r < 15) begin
      return 7'd0;
    end
    return 7'($urandom_range(127));
  endfunction

  initial begin
    int          done_items;
    int          pick;
    logic [6:0]  window_base;
    logic [6:0]  n;
    logic [15:0] phase_gain;

    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    kind         = '0;
    note         = '0;
    velocity     = '0;
    buffer_in    = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    idle_on      = 1'b1;
    quiet_cycles = 0;
    sb           = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, first with the reset gain
    // silent bank: output is just the buffer sample, both extremes
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh7fff);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, -16'sh8000);
    // unused kind must leave everything alone
    send(KIND_UNUSED, 7'd127, 7'd127, 16'sh7fff);
    send(pno_pkg::KIND_NOTE_ON, 7'd0, 7'd127, 16'sh0000);
    send(pno_pkg::KIND_NOTE_ON, 7'd127, 7'd127, 16'sh0000);
    send(pno_pkg::KIND_NOTE_ON, 7'd69, 7'd0, 16'sh0000);
    send(pno_pkg::KIND_NOTE_ON, 7'd60, 7'd1, 16'sh0000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh0000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh7fff);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, -16'sh8000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh0000);
    // retrigger of a sounding voice restarts its phase with the new amplitude
    send(pno_pkg::KIND_NOTE_ON, 7'd0, 7'd64, 16'sh0000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh3039);
    // note off of an active and of a silent voice
    send(pno_pkg::KIND_NOTE_OFF, 7'd127, 7'd0, 16'sh0000);
    send(pno_pkg::KIND_NOTE_OFF, 7'd5, 7'd0, 16'sh0000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, -16'sh0001);

    // full gain: older voices keep the amplitude they started with
    settle();
    write_gain(16'hffff);
    send(pno_pkg::KIND_NOTE_ON, 7'd64, 7'd127, 16'sh0000);
    send(pno_pkg::KIND_NOTE_ON, 7'd127, 7'd127, 16'sh0000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh7fff);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, -16'sh8000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh0000);

    // zero gain gives silent voices even at full velocity
    settle();
    write_gain(16'h0000);
    send(pno_pkg::KIND_NOTE_ON, 7'd100, 7'd127, 16'sh0000);
    send(pno_pkg::KIND_NOTE_ON, 7'd0, 7'd127, 16'sh0000);
    send(pno_pkg::KIND_TICK, 7'd0, 7'd0, 16'sh0000);

    // random part: one gain per phase, notes mostly from a narrow window so that
    // chords build up and get released again
    done_items = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       phase_gain = 16'h0000;
        1:       phase_gain = 16'hffff;
        2:       phase_gain = pno_pkg::GAIN_RESET;
        3:       phase_gain = 16'h0001;
        default: phase_gain = 16'($urandom);
      endcase
      // one phase runs back to back with no idling on either side
      idle_on     = (ph != 2);
      window_base = 7'($urandom_range(127));
      settle();
      write_gain(phase_gain);
      while (done_items < (RANDOM_ITEMS * (ph + 1)) / PHASES) begin
        pick = $urandom_range(99);
        if ($urandom_range(99) < 80) begin
          n = window_base + 7'($urandom_range(15));
        end else begin
          n = 7'($urandom_range(127));
        end
        if (pick < 5) begin
          // ignored request, not counted
          send(KIND_UNUSED, 7'($urandom), 7'($urandom), 16'($urandom));
        end else begin
          if (pick < 40) begin
            send(pno_pkg::KIND_NOTE_ON, n, pick_velocity(), 16'($urandom));
          end else if (pick < 58) begin
            send(pno_pkg::KIND_NOTE_OFF, n, 7'($urandom), 16'($urandom));
          end else begin
            send(pno_pkg::KIND_TICK, 7'($urandom), 7'($urandom), pick_sample());
          end
          done_items++;
        end
      end
    end

    // drain: wait for the last samples, then a full walk more for strays
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pno_pkg.sv
hw/rtl/pno_voice_mem.sv
hw/rtl/pno_sine_rom.sv
hw/rtl/pno_amp_calc.sv
hw/rtl/polyphonic_note_oscillator_core.sv
bench/polyphonic_note_oscillator_core_tb.sv
